FILE: rtl/spfd_pkg.sv
// Shared types and constants for the skeletal pose frame decoder.
// Holds the controller state type, command/status bundles and the MAC program.
// No dependencies.
package spfd_pkg;

    localparam logic [63:0]        ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // program counter landmarks in the MAC program
    localparam logic [5:0] PC_W_END   = 6'd2;
    localparam logic [5:0] PC_R_START = 6'd3;
    localparam logic [5:0] PC_R_END   = 6'd48;
    localparam logic [5:0] PC_C_START = 6'd49;
    localparam logic [5:0] PC_C_END   = 6'd52;

    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd30;

    typedef enum logic [4:0] {
        OP_T0, OP_T1, OP_T2,
        OP_Q0, OP_Q1, OP_Q2, OP_Q3,
        OP_PX, OP_PY, OP_PZ, OP_PW,
        OP_PT0, OP_PT1, OP_PT2,
        OP_UV0, OP_UV1, OP_UV2,
        OP_UUV0, OP_UUV1, OP_UUV2,
        OP_C0, OP_C1, OP_C2, OP_C3,
        OP_ONE
    } t_opnd;

    typedef enum logic [3:0] {
        D_SUM,
        D_UV0, D_UV1, D_UV2,
        D_UUV0, D_UUV1, D_UUV2,
        D_WT0, D_WT1, D_WT2,
        D_C0, D_C1, D_C2, D_C3
    } t_dest;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  first;   // clear accumulator
        logic  neg;     // subtract term
        logic  raw;     // full product, no Q30 scaling
        t_dest dst;
    } t_uop;

    typedef enum logic [3:0] {
        S_IDLE, S_MERGE, S_MUL, S_ACC, S_SQI, S_SQRT, S_SQD,
        S_RCOPY, S_IDENT, S_DINIT, S_DIV, S_DDONE, S_HALVE, S_WRITE
    } t_state;

    typedef struct packed {
        logic       merge;
        logic       mul;
        logic       acc;
        logic [5:0] pc;
        logic       sq_init;
        logic       sq_mode_c;
        logic       sq_step;
        logic       set_q3;
        logic       root_copy;
        logic       set_ident;
        logic       div_init;
        logic       div_step;
        logic       div_done;
        logic       halve;
        logic       write;
    } t_cmd;

    typedef struct packed {
        logic dec_ok;   // incoming transaction is an in-range decode
        logic root;
        logic big;      // product quaternion still outside +/-(2^31-1)
        logic sq_zero;
        logic out_free;
    } t_stat;

    function automatic t_uop mk(input t_opnd a, input t_opnd b, input logic first,
                                input logic neg, input logic raw, input t_dest dst);
        t_uop u;
        u.a = a; u.b = b; u.first = first; u.neg = neg; u.raw = raw; u.dst = dst;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [5:0] pc);
        t_uop u;
        case (pc)
            // sum of squares for w rebuild
            6'd0:  u = mk(OP_Q0, OP_Q0, 1'b1, 1'b0, 1'b1, D_SUM);
            6'd1:  u = mk(OP_Q1, OP_Q1, 1'b0, 1'b0, 1'b1, D_SUM);
            6'd2:  u = mk(OP_Q2, OP_Q2, 1'b0, 1'b0, 1'b1, D_SUM);
            // u x t
            6'd3:  u = mk(OP_PY, OP_T2, 1'b1, 1'b0, 1'b0, D_UV0);
            6'd4:  u = mk(OP_PZ, OP_T1, 1'b0, 1'b1, 1'b0, D_UV0);
            6'd5:  u = mk(OP_PZ, OP_T0, 1'b1, 1'b0, 1'b0, D_UV1);
            6'd6:  u = mk(OP_PX, OP_T2, 1'b0, 1'b1, 1'b0, D_UV1);
            6'd7:  u = mk(OP_PX, OP_T1, 1'b1, 1'b0, 1'b0, D_UV2);
            6'd8:  u = mk(OP_PY, OP_T0, 1'b0, 1'b1, 1'b0, D_UV2);
            // u x (u x t)
            6'd9:  u = mk(OP_PY, OP_UV2, 1'b1, 1'b0, 1'b0, D_UUV0);
            6'd10: u = mk(OP_PZ, OP_UV1, 1'b0, 1'b1, 1'b0, D_UUV0);
            6'd11: u = mk(OP_PZ, OP_UV0, 1'b1, 1'b0, 1'b0, D_UUV1);
            6'd12: u = mk(OP_PX, OP_UV2, 1'b0, 1'b1, 1'b0, D_UUV1);
            6'd13: u = mk(OP_PX, OP_UV1, 1'b1, 1'b0, 1'b0, D_UUV2);
            6'd14: u = mk(OP_PY, OP_UV0, 1'b0, 1'b1, 1'b0, D_UUV2);
            // t + 2*(w*uv + uuv) + pt, exact terms via multiply by one
            6'd15: u = mk(OP_UV0, OP_PW, 1'b1, 1'b0, 1'b0, D_WT0);
            6'd16: u = mk(OP_UV0, OP_PW, 1'b0, 1'b0, 1'b0, D_WT0);
            6'd17: u = mk(OP_UUV0, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT0);
            6'd18: u = mk(OP_UUV0, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT0);
            6'd19: u = mk(OP_T0, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT0);
            6'd20: u = mk(OP_PT0, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT0);
            6'd21: u = mk(OP_UV1, OP_PW, 1'b1, 1'b0, 1'b0, D_WT1);
            6'd22: u = mk(OP_UV1, OP_PW, 1'b0, 1'b0, 1'b0, D_WT1);
            6'd23: u = mk(OP_UUV1, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT1);
            6'd24: u = mk(OP_UUV1, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT1);
            6'd25: u = mk(OP_T1, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT1);
            6'd26: u = mk(OP_PT1, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT1);
            6'd27: u = mk(OP_UV2, OP_PW, 1'b1, 1'b0, 1'b0, D_WT2);
            6'd28: u = mk(OP_UV2, OP_PW, 1'b0, 1'b0, 1'b0, D_WT2);
            6'd29: u = mk(OP_UUV2, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT2);
            6'd30: u = mk(OP_UUV2, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT2);
            6'd31: u = mk(OP_T2, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT2);
            6'd32: u = mk(OP_PT2, OP_ONE, 1'b0, 1'b0, 1'b0, D_WT2);
            // quaternion product parent * local
            6'd33: u = mk(OP_PW, OP_Q3, 1'b1, 1'b0, 1'b0, D_C3);
            6'd34: u = mk(OP_PX, OP_Q0, 1'b0, 1'b1, 1'b0, D_C3);
            6'd35: u = mk(OP_PY, OP_Q1, 1'b0, 1'b1, 1'b0, D_C3);
            6'd36: u = mk(OP_PZ, OP_Q2, 1'b0, 1'b1, 1'b0, D_C3);
            6'd37: u = mk(OP_PW, OP_Q0, 1'b1, 1'b0, 1'b0, D_C0);
            6'd38: u = mk(OP_PX, OP_Q3, 1'b0, 1'b0, 1'b0, D_C0);
            6'd39: u = mk(OP_PY, OP_Q2, 1'b0, 1'b0, 1'b0, D_C0);
            6'd40: u = mk(OP_PZ, OP_Q1, 1'b0, 1'b1, 1'b0, D_C0);
            6'd41: u = mk(OP_PW, OP_Q1, 1'b1, 1'b0, 1'b0, D_C1);
            6'd42: u = mk(OP_PY, OP_Q3, 1'b0, 1'b0, 1'b0, D_C1);
            6'd43: u = mk(OP_PZ, OP_Q0, 1'b0, 1'b0, 1'b0, D_C1);
            6'd44: u = mk(OP_PX, OP_Q2, 1'b0, 1'b1, 1'b0, D_C1);
            6'd45: u = mk(OP_PW, OP_Q2, 1'b1, 1'b0, 1'b0, D_C2);
            6'd46: u = mk(OP_PZ, OP_Q3, 1'b0, 1'b0, 1'b0, D_C2);
            6'd47: u = mk(OP_PX, OP_Q1, 1'b0, 1'b0, 1'b0, D_C2);
            6'd48: u = mk(OP_PY, OP_Q0, 1'b0, 1'b1, 1'b0, D_C2);
            // norm squared of the product
            6'd49: u = mk(OP_C0, OP_C0, 1'b1, 1'b0, 1'b1, D_SUM);
            6'd50: u = mk(OP_C1, OP_C1, 1'b0, 1'b0, 1'b1, D_SUM);
            6'd51: u = mk(OP_C2, OP_C2, 1'b0, 1'b0, 1'b1, D_SUM);
            6'd52: u = mk(OP_C3, OP_C3, 1'b0, 1'b0, 1'b1, D_SUM);
            default: u = mk(OP_ONE, OP_ONE, 1'b1, 1'b0, 1'b1, D_SUM);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/spfd_ctrl.sv
// Sequencing controller for the skeletal pose frame decoder.
// Steps the MAC program, square root, normalising and divide phases.
// Depends on spfd_pkg.
module spfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  spfd_pkg::t_stat i_sts,
    output spfd_pkg::t_cmd  o_ctl,
    output logic            o_in_ready
);
    import spfd_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_pc, n_pc;
    logic [4:0] r_cnt, n_cnt;
    logic       r_mode, n_mode;   // 1: norm of product, 0: w rebuild

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_cnt      = r_cnt;
        n_mode     = r_mode;
        o_ctl      = '0;
        o_ctl.pc   = r_pc;
        o_ctl.sq_mode_c = r_mode;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_accept && i_sts.dec_ok) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                o_ctl.merge = 1'b1;
                n_pc    = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_ctl.acc = 1'b1;
                if (r_pc == PC_W_END) begin
                    n_mode  = 1'b0;
                    n_state = S_SQI;
                end else if (r_pc == PC_R_END) begin
                    n_state = S_HALVE;
                end else if (r_pc == PC_C_END) begin
                    n_mode  = 1'b1;
                    n_state = S_SQI;
                end else begin
                    n_pc    = r_pc + 6'd1;
                    n_state = S_MUL;
                end
            end
            S_SQI: begin
                o_ctl.sq_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_ctl.sq_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_SQD;
                end
            end
            S_SQD: begin
                if (!r_mode) begin
                    o_ctl.set_q3 = 1'b1;
                    if (i_sts.root) begin
                        n_state = S_RCOPY;
                    end else begin
                        n_pc    = PC_R_START;
                        n_state = S_MUL;
                    end
                end else if (i_sts.sq_zero) begin
                    n_state = S_IDENT;
                end else begin
                    n_state = S_DINIT;
                end
            end
            S_RCOPY: begin
                o_ctl.root_copy = 1'b1;
                n_state = S_WRITE;
            end
            S_IDENT: begin
                o_ctl.set_ident = 1'b1;
                n_state = S_WRITE;
            end
            S_DINIT: begin
                o_ctl.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                o_ctl.div_done = 1'b1;
                n_state = S_WRITE;
            end
            S_HALVE: begin
                if (i_sts.big) begin
                    o_ctl.halve = 1'b1;
                end else begin
                    n_pc    = PC_C_START;
                    n_state = S_MUL;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_ctl.write = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/spfd_dp.sv
// Datapath of the skeletal pose frame decoder: pose stores, shared MAC,
// square root and four-lane divider, output register.
// Depends on spfd_pkg.
module spfd_dp #(
    parameter int MAX_BONES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_cmd,
    input  logic [5:0]          i_bone_index,
    input  logic [5:0]          i_channel_mask,
    input  logic signed [6:0]   i_parent_index,
    input  logic signed [31:0]  i_word_0,
    input  logic signed [31:0]  i_word_1,
    input  logic signed [31:0]  i_word_2,
    input  logic signed [31:0]  i_word_3,
    input  logic signed [31:0]  i_word_4,
    input  logic signed [31:0]  i_word_5,
    input  logic                i_last_bone,
    input  logic                i_out_ready,
    input  spfd_pkg::t_cmd      i_ctl,
    output spfd_pkg::t_stat     o_sts,
    output logic                o_out_valid,
    output logic [5:0]          o_out_bone,
    output logic signed [31:0]  o_world_tx,
    output logic signed [31:0]  o_world_ty,
    output logic signed [31:0]  o_world_tz,
    output logic signed [31:0]  o_world_qx,
    output logic signed [31:0]  o_world_qy,
    output logic signed [31:0]  o_world_qz,
    output logic signed [31:0]  o_world_qw,
    output logic                o_frame_done
);
    import spfd_pkg::*;

    localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    localparam logic signed [65:0] S_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S_MIN = -66'sd2147483648;
    localparam logic signed [39:0] C_MAX = 40'sd2147483647;
    localparam logic signed [39:0] C_MIN = -40'sd2147483647;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S_MAX) return 32'sh7fff_ffff;
        if (v < S_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // stores
    logic [191:0] r_base_mem [MAX_BONES];
    logic [223:0] r_pose_mem [MAX_BONES];
    logic [191:0] r_base_rd;
    logic [223:0] r_pose_rd;

    logic [15:0]   bone_ext, par_ext, wr_ext;
    logic [AW-1:0] bone_addr, par_addr;
    logic          bone_ok;

    // transaction registers
    logic [5:0]         r_bone;
    logic [5:0]         r_mask;
    logic               r_last, r_root;
    logic signed [31:0] r_word [6];

    // working registers
    logic signed [31:0] r_t [3];
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_uv [3];
    logic signed [31:0] r_uuv [3];
    logic signed [31:0] r_wt [3];
    logic signed [31:0] r_wq [4];
    logic signed [39:0] r_c [4];
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic [63:0]        r_sum;

    logic [63:0] r_sq_n, r_sq_r, r_sq_bit;
    logic        r_wzero;

    logic [33:0] r_rem [4];
    logic [30:0] r_quo [4];

    logic               r_out_valid;
    logic [5:0]         r_o_bone;
    logic signed [31:0] r_o_wt [3];
    logic signed [31:0] r_o_wq [4];
    logic               r_o_last;

    assign bone_ext  = {10'b0, i_bone_index};
    assign par_ext   = {10'b0, i_parent_index[5:0]};
    assign wr_ext    = {10'b0, r_bone};
    assign bone_addr = bone_ext[AW-1:0];
    assign par_addr  = par_ext[AW-1:0];
    assign bone_ok   = ({26'b0, i_bone_index} < 32'(MAX_BONES));

    // store access: base write and reads at acceptance, pose write-back on write
    always_ff @(posedge i_clk) begin
        if (i_accept && bone_ok && !i_cmd) begin
            r_base_mem[bone_addr] <= {i_word_5, i_word_4, i_word_3,
                                      i_word_2, i_word_1, i_word_0};
        end
        if (i_accept) begin
            r_base_rd <= r_base_mem[bone_addr];
            r_pose_rd <= r_pose_mem[par_addr];
        end
        if (i_ctl.write) begin
            r_pose_mem[wr_ext[AW-1:0]] <= {r_wq[3], r_wq[2], r_wq[1], r_wq[0],
                                           r_wt[2], r_wt[1], r_wt[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_bone    <= i_bone_index;
            r_mask    <= i_channel_mask;
            r_last    <= i_last_bone;
            r_root    <= i_parent_index[6] ||
                         ({26'b0, i_parent_index[5:0]} >= 32'(MAX_BONES));
            r_word[0] <= i_word_0;
            r_word[1] <= i_word_1;
            r_word[2] <= i_word_2;
            r_word[3] <= i_word_3;
            r_word[4] <= i_word_4;
            r_word[5] <= i_word_5;
        end
    end

    // channel merge: packed words replace base components in mask order
    logic signed [31:0] m_v [6];
    always_comb begin
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < 6; i++) begin
            m_v[i] = r_base_rd[32*i +: 32];
            if (r_mask[i]) begin
                m_v[i] = r_word[k];
                k = k + 3'd1;
            end
        end
    end

    // MAC operand selection
    t_uop u;
    assign u = uop_rom(i_ctl.pc);

    function automatic logic signed [31:0] pick(input t_opnd s);
        case (s)
            OP_T0:   return r_t[0];
            OP_T1:   return r_t[1];
            OP_T2:   return r_t[2];
            OP_Q0:   return r_q[0];
            OP_Q1:   return r_q[1];
            OP_Q2:   return r_q[2];
            OP_Q3:   return r_q[3];
            OP_PX:   return r_pose_rd[127:96];
            OP_PY:   return r_pose_rd[159:128];
            OP_PZ:   return r_pose_rd[191:160];
            OP_PW:   return r_pose_rd[223:192];
            OP_PT0:  return r_pose_rd[31:0];
            OP_PT1:  return r_pose_rd[63:32];
            OP_PT2:  return r_pose_rd[95:64];
            OP_UV0:  return r_uv[0];
            OP_UV1:  return r_uv[1];
            OP_UV2:  return r_uv[2];
            OP_UUV0: return r_uuv[0];
            OP_UUV1: return r_uuv[1];
            OP_UUV2: return r_uuv[2];
            OP_C0:   return r_c[0][31:0];
            OP_C1:   return r_c[1][31:0];
            OP_C2:   return r_c[2][31:0];
            OP_C3:   return r_c[3][31:0];
            default: return ONE_Q30;
        endcase
    endfunction

    logic signed [31:0] a_val, b_val;
    logic signed [63:0] p_sh;
    logic signed [65:0] term, acc_next;
    logic signed [31:0] acc_sat;

    always_comb begin
        a_val    = pick(u.a);
        b_val    = pick(u.b);
        p_sh     = r_prod >>> 30;
        term     = u.raw ? 66'(r_prod) : 66'(p_sh);
        acc_next = (u.first ? 66'sd0 : r_acc) + (u.neg ? -term : term);
        acc_sat  = sat32(acc_next);
    end

    // square root step
    logic [63:0] sq_rb;
    assign sq_rb = r_sq_r + r_sq_bit;

    // divide lanes
    logic [31:0] dv_n;
    assign dv_n = r_sq_r[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge) begin
            for (int i = 0; i < 3; i++) r_t[i] <= m_v[i];
            for (int i = 0; i < 3; i++) r_q[i] <= m_v[i+3];
        end
        if (i_ctl.mul) begin
            r_prod <= 64'(a_val) * 64'(b_val);
        end
        if (i_ctl.acc) begin
            r_acc <= acc_next;
            case (u.dst)
                D_SUM:   r_sum    <= acc_next[63:0];
                D_UV0:   r_uv[0]  <= acc_sat;
                D_UV1:   r_uv[1]  <= acc_sat;
                D_UV2:   r_uv[2]  <= acc_sat;
                D_UUV0:  r_uuv[0] <= acc_sat;
                D_UUV1:  r_uuv[1] <= acc_sat;
                D_UUV2:  r_uuv[2] <= acc_sat;
                D_WT0:   r_wt[0]  <= acc_sat;
                D_WT1:   r_wt[1]  <= acc_sat;
                D_WT2:   r_wt[2]  <= acc_sat;
                D_C0:    r_c[0]   <= acc_next[39:0];
                D_C1:    r_c[1]   <= acc_next[39:0];
                D_C2:    r_c[2]   <= acc_next[39:0];
                D_C3:    r_c[3]   <= acc_next[39:0];
                default: r_sum    <= r_sum;
            endcase
        end
        if (i_ctl.sq_init) begin
            r_sq_n   <= i_ctl.sq_mode_c ? r_sum : (ONE_Q60 - r_sum);
            r_sq_r   <= '0;
            r_sq_bit <= 64'h4000_0000_0000_0000;
            r_wzero  <= (r_sum > ONE_Q60);
        end
        if (i_ctl.sq_step) begin
            if (r_sq_n >= sq_rb) begin
                r_sq_n <= r_sq_n - sq_rb;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_ctl.set_q3) begin
            r_q[3] <= r_wzero ? 32'sd0 : $signed(32'd0 - r_sq_r[31:0]);
        end
        if (i_ctl.halve) begin
            for (int i = 0; i < 4; i++) r_c[i] <= r_c[i] >>> 1;
        end
        if (i_ctl.div_init) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= {2'b0, (r_c[i][39] ? (32'd0 - r_c[i][31:0]) : r_c[i][31:0])};
                r_quo[i] <= '0;
            end
        end
        if (i_ctl.div_step) begin
            for (int i = 0; i < 4; i++) begin
                if (r_rem[i] >= {2'b0, dv_n}) begin
                    r_rem[i] <= (r_rem[i] - {2'b0, dv_n}) << 1;
                    r_quo[i] <= {r_quo[i][29:0], 1'b1};
                end else begin
                    r_rem[i] <= r_rem[i] << 1;
                    r_quo[i] <= {r_quo[i][29:0], 1'b0};
                end
            end
        end
        if (i_ctl.div_done) begin
            for (int i = 0; i < 4; i++) begin
                r_wq[i] <= r_c[i][39] ? $signed(32'd0 - {1'b0, r_quo[i]})
                                      : $signed({1'b0, r_quo[i]});
            end
        end
        if (i_ctl.set_ident) begin
            r_wq[0] <= 32'sd0;
            r_wq[1] <= 32'sd0;
            r_wq[2] <= 32'sd0;
            r_wq[3] <= ONE_Q30;
        end
        if (i_ctl.root_copy) begin
            for (int i = 0; i < 3; i++) r_wt[i] <= r_t[i];
            for (int i = 0; i < 4; i++) r_wq[i] <= r_q[i];
        end
        if (i_ctl.write) begin
            r_o_bone <= r_bone;
            r_o_last <= r_last;
            for (int i = 0; i < 3; i++) r_o_wt[i] <= r_wt[i];
            for (int i = 0; i < 4; i++) r_o_wq[i] <= r_wq[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.dec_ok   = i_cmd && bone_ok;
        o_sts.root     = r_root;
        o_sts.big      = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_c[i] > C_MAX || r_c[i] < C_MIN) o_sts.big = 1'b1;
        end
        o_sts.sq_zero  = (r_sq_r == 64'd0);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_bone   = r_o_bone;
    assign o_world_tx   = r_o_wt[0];
    assign o_world_ty   = r_o_wt[1];
    assign o_world_tz   = r_o_wt[2];
    assign o_world_qx   = r_o_wq[0];
    assign o_world_qy   = r_o_wq[1];
    assign o_world_qz   = r_o_wq[2];
    assign o_world_qw   = r_o_wq[3];
    assign o_frame_done = r_o_last;

endmodule

FILE: rtl/skeletal_pose_frame_decode.sv
// Top level of the skeletal pose frame decoder.
// Joins spfd_ctrl and spfd_dp; depends on spfd_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one bone transaction.
//   cmd 0 stores the bone's base pose; it produces no result and the block is
//   ready again in the next cycle. cmd 1 decodes the bone against the stored
//   base and its parent's stored world pose, and produces one result
//   transaction on the output channel (o_out_valid / i_out_ready).
//   Bones with an index at or above MAX_BONES are dropped silently.
//   Only one decode runs at a time. A root bone runs merge, three squares,
//   a 32-step square root, copy and write. A child bone runs 53
//   multiply-accumulate steps on the one shared 32x32 multiplier, with any
//   normalising halving steps between the product and its norm, two 32-step
//   square roots and a 31-step divide run over four lanes in parallel;
//   a zero product skips the divide. o_out_valid rises when the output
//   register is loaded in the final write step; o_in_ready is high again
//   from the cycle after that write. Result is held in an output register,
//   so the next bone is accepted while it waits; if the receiver stalls,
//   the following decode waits at its end until the register is free.
//   Reset clears the controller and the output valid only; pose stores keep
//   whatever they hold and must be loaded/decoded before being read.
module skeletal_pose_frame_decode #(
    parameter int MAX_BONES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_bone_index,
    input  logic [5:0]         i_channel_mask,
    input  logic signed [6:0]  i_parent_index,
    input  logic signed [31:0] i_word_0,
    input  logic signed [31:0] i_word_1,
    input  logic signed [31:0] i_word_2,
    input  logic signed [31:0] i_word_3,
    input  logic signed [31:0] i_word_4,
    input  logic signed [31:0] i_word_5,
    input  logic               i_last_bone,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_out_bone,
    output logic signed [31:0] o_world_tx,
    output logic signed [31:0] o_world_ty,
    output logic signed [31:0] o_world_tz,
    output logic signed [31:0] o_world_qx,
    output logic signed [31:0] o_world_qy,
    output logic signed [31:0] o_world_qz,
    output logic signed [31:0] o_world_qw,
    output logic               o_frame_done
);
    import spfd_pkg::*;

    t_cmd  ctl;
    t_stat sts;
    logic  accept;

    // a transaction moves when both sides agree
    assign accept = i_in_valid && o_in_ready;

    spfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_ready (o_in_ready)
    );

    spfd_dp #(.MAX_BONES(MAX_BONES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_bone_index   (i_bone_index),
        .i_channel_mask (i_channel_mask),
        .i_parent_index (i_parent_index),
        .i_word_0       (i_word_0),
        .i_word_1       (i_word_1),
        .i_word_2       (i_word_2),
        .i_word_3       (i_word_3),
        .i_word_4       (i_word_4),
        .i_word_5       (i_word_5),
        .i_last_bone    (i_last_bone),
        .i_out_ready    (i_out_ready),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_out_bone     (o_out_bone),
        .o_world_tx     (o_world_tx),
        .o_world_ty     (o_world_ty),
        .o_world_tz     (o_world_tz),
        .o_world_qx     (o_world_qx),
        .o_world_qy     (o_world_qy),
        .o_world_qz     (o_world_qz),
        .o_world_qw     (o_world_qw),
        .o_frame_done   (o_frame_done)
    );

endmodule

FILE: rtl/spfd_chk.sv
// Port-level checks for the skeletal pose frame decoder.
// Bound to skeletal_pose_frame_decode; no package needed.
module spfd_chk #(
    parameter int MAX_BONES = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_cmd,
    input logic [5:0]         i_bone_index,
    input logic [5:0]         i_channel_mask,
    input logic signed [6:0]  i_parent_index,
    input logic signed [31:0] i_word_0,
    input logic signed [31:0] i_word_1,
    input logic signed [31:0] i_word_2,
    input logic signed [31:0] i_word_3,
    input logic signed [31:0] i_word_4,
    input logic signed [31:0] i_word_5,
    input logic               i_last_bone,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [5:0]         o_out_bone,
    input logic signed [31:0] o_world_tx,
    input logic signed [31:0] o_world_ty,
    input logic signed [31:0] o_world_tz,
    input logic signed [31:0] o_world_qx,
    input logic signed [31:0] o_world_qy,
    input logic signed [31:0] o_world_qz,
    input logic signed [31:0] o_world_qw,
    input logic               o_frame_done
);

    // no result survives reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result stays valid with its bone and qw held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_bone) && $stable(o_world_qw)))
        else $error("stalled result changed");

    // an in-range decode occupies the block
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_cmd &&
         ({26'b0, i_bone_index} < 32'(MAX_BONES))) |=> !o_in_ready)
        else $error("decode did not occupy the block");

    // a load transaction leaves the block free
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_cmd) |=> o_in_ready)
        else $error("load stalled the input");

endmodule

bind skeletal_pose_frame_decode spfd_chk #(.MAX_BONES(MAX_BONES)) u_chk (.*);
